// ----- hw/rtl/pit_pkg.sv -----
// shared types, register map codes and defaults of the periodic interrupt timer
package pit_pkg;

    localparam int DEF_CHANNELS      = 4;
    localparam int DEF_COUNTER_WIDTH = 32;

    // transaction kinds
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // register offsets within a channel
    localparam logic [1:0] OFF_LOAD    = 2'd0;
    localparam logic [1:0] OFF_CURRENT = 2'd1;
    localparam logic [1:0] OFF_CONTROL = 2'd2;
    localparam logic [1:0] OFF_FLAG    = 2'd3;

    localparam logic [4:0] MODULE_INDEX = 5'd16;

    // bit positions in the control words
    localparam int BIT_TIMER_EN   = 0;
    localparam int BIT_IRQ_EN     = 1;
    localparam int BIT_FREEZE     = 0;
    localparam int BIT_MOD_DIS    = 1;
    localparam int BIT_FLAG_CLEAR = 0;

    typedef struct packed {
        logic [1:0]  mode;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic        debug_halt;
    } t_pit_in;

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  timer_flags;
        logic [3:0]  irq_lines;
    } t_pit_out;

    // per-channel strobes, valid only in the cycle of an accepted transaction
    typedef struct packed {
        logic tick;
        logic wr_load;
        logic wr_control;
        logic wr_flag;
    } t_chan_ctrl;

endpackage

// ----- hw/rtl/periodic_interrupt_timer_unit.sv -----
// top level of the periodic interrupt timer with its valid/ready transaction ports

// A multi-channel periodic interrupt timer driven by a stream of transactions:
// each transaction is a clock tick, a register write or a register read, and
// produces exactly one result carrying the read data (zero unless a read),
// the timeout flags and the interrupt lines as they stand after it. One
// transaction is accepted per clock cycle; all its work is a single pass of
// logic from the input into the state and the result register, so the
// throughput is one transaction per cycle while the output is not stalled,
// and the result is valid in the cycle after its transaction is accepted. A
// new transaction is taken in the same cycle as the waiting result leaves;
// while a result waits for the consumer the input is held off. After reset
// the module is disabled (module control bit 1 set) and all channels are
// stopped with zero load and count; ticks do nothing until software clears
// the disable bit. Channels beyond four are counted but do not appear in
// the flag and interrupt fields.
module periodic_interrupt_timer_unit
    import pit_pkg::*;
#(
    parameter int CHANNELS      = DEF_CHANNELS,
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_pit_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pit_out o_out_data
);

    // module control
    logic r_disabled, n_disabled;
    logic r_freeze, n_freeze;

    // output register
    logic     r_out_valid;
    t_pit_out r_out, n_out;

    logic accept;
    logic is_tick, is_write, is_read;
    logic is_module;
    logic run_tick;
    logic [2:0] chan_sel;

    t_chan_ctrl        chan_ctrl [CHANNELS];
    logic [31:0]       chan_rd   [CHANNELS];
    logic [CHANNELS-1:0] next_flag;
    logic [CHANNELS-1:0] next_irq;

    // free slot in the result register, or the waiting result leaves now
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        is_tick  = 1'b0;
        is_write = 1'b0;
        is_read  = 1'b0;
        unique case (i_in_data.mode)
            MODE_TICK:  is_tick  = 1'b1;
            MODE_WRITE: is_write = 1'b1;
            MODE_READ:  is_read  = 1'b1;
            default:    ; // unused mode changes nothing
        endcase
    end

    // module control at its index shadows any channel register there
    assign is_module = (i_in_data.reg_index == MODULE_INDEX);
    assign chan_sel  = i_in_data.reg_index[4:2];

    // ticks are dropped while disabled or frozen in debug
    assign run_tick = accept && is_tick && !r_disabled
                      && !(r_freeze && i_in_data.debug_halt);

    genvar c;
    generate
        for (c = 0; c < CHANNELS; c++) begin : g_chan
            logic hit;
            assign hit = !is_module && (chan_sel == 3'(c));

            always_comb begin
                chan_ctrl[c].tick       = run_tick;
                chan_ctrl[c].wr_load    = accept && is_write && hit
                                          && (i_in_data.reg_index[1:0] == OFF_LOAD);
                chan_ctrl[c].wr_control = accept && is_write && hit
                                          && (i_in_data.reg_index[1:0] == OFF_CONTROL);
                chan_ctrl[c].wr_flag    = accept && is_write && hit
                                          && (i_in_data.reg_index[1:0] == OFF_FLAG);
            end

            pit_channel #(
                .COUNTER_WIDTH(COUNTER_WIDTH)
            ) u_chan (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (chan_ctrl[c]),
                .i_write_data (i_in_data.write_data),
                .i_offset     (i_in_data.reg_index[1:0]),
                .o_read_data  (chan_rd[c]),
                .o_next_flag  (next_flag[c]),
                .o_next_irq   (next_irq[c])
            );
        end
    endgenerate

    // module control register update
    always_comb begin
        n_disabled = r_disabled;
        n_freeze   = r_freeze;
        if (accept && is_write && is_module) begin
            n_disabled = i_in_data.write_data[BIT_MOD_DIS];
            n_freeze   = i_in_data.write_data[BIT_FREEZE];
        end
    end

    // result: read mux plus the flag and interrupt state after this transaction
    always_comb begin
        n_out = '0;
        if (is_read) begin
            if (is_module) begin
                n_out.read_data[BIT_MOD_DIS] = r_disabled;
                n_out.read_data[BIT_FREEZE]  = r_freeze;
            end else begin
                for (int k = 0; k < CHANNELS; k++) begin
                    if (chan_sel == 3'(k)) begin
                        n_out.read_data = n_out.read_data | chan_rd[k];
                    end
                end
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (k < CHANNELS) begin
                n_out.timer_flags[k] = next_flag[k];
                n_out.irq_lines[k]   = next_irq[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disabled  <= 1'b1;
            r_freeze    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_disabled <= n_disabled;
            r_freeze   <= n_freeze;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- hw/rtl/pit_channel.sv -----
// one timer channel: load, count, enables and timeout flag
module pit_channel
    import pit_pkg::*;
#(
    parameter int COUNTER_WIDTH = DEF_COUNTER_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chan_ctrl  i_ctrl,
    input  logic [31:0] i_write_data,
    input  logic [1:0]  i_offset,
    output logic [31:0] o_read_data,
    output logic        o_next_flag,
    output logic        o_next_irq
);

    logic [COUNTER_WIDTH-1:0] r_load, n_load;
    logic [COUNTER_WIDTH-1:0] r_count, n_count;
    logic                     r_en, n_en;
    logic                     r_ie, n_ie;
    logic                     r_flag, n_flag;

    always_comb begin
        n_load  = r_load;
        n_count = r_count;
        n_en    = r_en;
        n_ie    = r_ie;
        n_flag  = r_flag;
        if (i_ctrl.tick && r_en) begin
            if (r_count == '0) begin
                n_count = r_load;
                n_flag  = 1'b1;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
        if (i_ctrl.wr_load) begin
            n_load = i_write_data[COUNTER_WIDTH-1:0];
        end
        if (i_ctrl.wr_control) begin
            // rising enable restarts from the load value
            if (i_write_data[BIT_TIMER_EN] && !r_en) begin
                n_count = r_load;
            end
            n_en = i_write_data[BIT_TIMER_EN];
            n_ie = i_write_data[BIT_IRQ_EN];
        end
        if (i_ctrl.wr_flag && i_write_data[BIT_FLAG_CLEAR]) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_count <= '0;
            r_en    <= 1'b0;
            r_ie    <= 1'b0;
            r_flag  <= 1'b0;
        end else begin
            r_load  <= n_load;
            r_count <= n_count;
            r_en    <= n_en;
            r_ie    <= n_ie;
            r_flag  <= n_flag;
        end
    end

    always_comb begin
        unique case (i_offset)
            OFF_LOAD:    o_read_data = 32'(r_load);
            OFF_CURRENT: o_read_data = 32'(r_count);
            OFF_CONTROL: o_read_data = {30'd0, r_ie, r_en};
            OFF_FLAG:    o_read_data = {31'd0, r_flag};
            default:     o_read_data = '0;
        endcase
    end

    assign o_next_flag = n_flag;
    assign o_next_irq  = n_flag & n_ie;

endmodule
